@@ sv/rmc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range matrix consensus package
// Widths, request codes, register indexes and reset values shared by the
// channel interfaces and the range matrix block.
// ----------------------------------------------------------------------------
package rmc_pkg;

	// Default sizes for the top level parameters.
	localparam int MAX_NODES_DEF    = 8;
	localparam int BUFFER_DEPTH_DEF = 64;

	// Field widths.
	localparam int REQ_W      = 3;
	localparam int ID_W       = 3;
	localparam int DIST_W     = 20;
	localparam int RANGE_W    = 21;
	localparam int CNT_W      = 4;
	localparam int MASK_W     = 1 << ID_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	// Request codes carried in req_type.
	typedef enum logic [REQ_W-1:0] {
		REQ_ENTRY      = 3'd0,
		REQ_REPORT     = 3'd1,
		REQ_OWN_END    = 3'd2,
		REQ_REMOTE_END = 3'd3,
		REQ_PUBLISH    = 3'd4
	} req_code_t;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_NODES   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REQUIRED_NODES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THRESHOLD = 2'd2;

	// Register reset values.
	localparam logic [CNT_W-1:0]  ACTIVE_NODES_RST   = 4'd6;
	localparam logic [CNT_W-1:0]  REQUIRED_NODES_RST = 4'd5;
	localparam logic [DIST_W-1:0] DIFF_THRESHOLD_RST = 20'd500;

endpackage

@@ sv/rmc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range matrix consensus channels
// Valid/ready channels for request items and published matrix elements.
// ----------------------------------------------------------------------------

// Request channel: one item per entry, report mark, frame end or publish.
interface rmc_req_if;
	import rmc_pkg::*;

	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [ID_W-1:0]   src_node;
	logic [ID_W-1:0]   tgt_node;
	logic [DIST_W-1:0] distance_mm;

	modport source (output valid, output req_type, output src_node, output tgt_node,
		output distance_mm, input ready);
	modport sink (input valid, input req_type, input src_node, input tgt_node,
		input distance_mm, output ready);
endinterface

// Result channel: one item per published matrix element.
interface rmc_rsp_if;
	import rmc_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [ID_W-1:0]           row_id;
	logic [ID_W-1:0]           col_id;
	logic signed [RANGE_W-1:0] range_value;
	logic                      last_element;
	logic                      overflow_seen;

	modport source (output valid, output row_id, output col_id, output range_value,
		output last_element, output overflow_seen, input ready);
	modport sink (input valid, input row_id, input col_id, input range_value,
		input last_element, input overflow_seen, output ready);
endinterface

@@ sv/range_matrix_consensus.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range matrix consensus
// Buffers node-to-node range entries, commits them to a range matrix once
// enough nodes have reported, and publishes the symmetric consensus matrix.
// ----------------------------------------------------------------------------
// Entries and report marks leave the request channel ready; a frame end does
// too unless it starts a commit. A commit walks the pending buffer through its
// single registered read port and the matrix write port, with a read state and
// a write state per buffered entry. A publish walks the matrix one element at a
// time through a shared read, add/subtract and compare path in read, calculate
// and output states, holding in the output state while the result channel
// stalls. The request channel is not ready during a commit or a publish. The
// matrix starts as all unknown right after reset; no clearing pass is needed.
module range_matrix_consensus #(
	parameter int MAX_NODES    = rmc_pkg::MAX_NODES_DEF,
	parameter int BUFFER_DEPTH = rmc_pkg::BUFFER_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rmc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	rmc_req_if.sink                        req,
	rmc_rsp_if.source                      rsp
);
	import rmc_pkg::*;

	localparam int CELLS = MAX_NODES * MAX_NODES;
	localparam int AW    = $clog2(CELLS);
	localparam int PW    = $clog2(BUFFER_DEPTH);
	localparam int PCW   = $clog2(BUFFER_DEPTH + 1);

	typedef struct packed {
		logic [ID_W-1:0]   src;
		logic [ID_W-1:0]   tgt;
		logic [DIST_W-1:0] dist_mm;
	} pend_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMT_RD,
		ST_CMT_WR,
		ST_PUB_RD,
		ST_PUB_CALC,
		ST_PUB_OUT
	} state_t;

	// Configuration registers.
	logic [CNT_W-1:0]  active_nodes_q;
	logic [CNT_W-1:0]  required_nodes_q;
	logic [DIST_W-1:0] diff_threshold_q;

	// Control state.
	state_t            state_q;
	logic [PCW-1:0]    pend_cnt_q;
	logic [PCW-1:0]    cmt_idx_q;
	logic [MASK_W-1:0] reported_mask_q;
	logic              own_done_q;
	logic              overflow_q;
	logic [ID_W-1:0]   row_q;
	logic [ID_W-1:0]   col_q;

	// Memories and their registered read data.
	logic [DIST_W-1:0] range_mem [CELLS];
	logic [CELLS-1:0]  range_valid_q;
	pend_entry_t       pend_mem [BUFFER_DEPTH];
	pend_entry_t       pend_rd_q;
	logic [DIST_W-1:0] rd_a_q;
	logic [DIST_W-1:0] rd_b_q;
	logic              rd_a_valid_q;
	logic              rd_b_valid_q;

	// Arithmetic results of the consensus path.
	logic [DIST_W:0]   sum_q;
	logic [DIST_W-1:0] diff_q;

	// Output register.
	logic                      rsp_valid_q;
	logic [ID_W-1:0]           rsp_row_q;
	logic [ID_W-1:0]           rsp_col_q;
	logic signed [RANGE_W-1:0] rsp_range_q;
	logic                      rsp_last_q;
	logic                      rsp_ovf_q;

	// Combinational signals.
	logic [CNT_W-1:0]  node_lim;
	logic [CNT_W-1:0]  reported_cnt;
	logic              in_fire;
	logic              entry_ok;
	logic              pend_we;
	pend_entry_t       pend_wdata;
	logic              commit_ok_own;
	logic              commit_ok_remote;
	logic              range_we;
	logic [AW-1:0]     range_waddr;
	logic [AW-1:0]     addr_a;
	logic [AW-1:0]     addr_b;
	logic              row_last;
	logic              col_last;
	logic              out_free;
	logic signed [RANGE_W-1:0] cons_value;

	// Configuration writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_nodes_q   <= ACTIVE_NODES_RST;
			required_nodes_q <= REQUIRED_NODES_RST;
			diff_threshold_q <= DIFF_THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ACTIVE_NODES:   active_nodes_q   <= cfg_wdata[CNT_W-1:0];
				CFG_REQUIRED_NODES: required_nodes_q <= cfg_wdata[CNT_W-1:0];
				CFG_DIFF_THRESHOLD: diff_threshold_q <= cfg_wdata[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective node count and number of marked remote nodes.
	always_comb begin
		node_lim = (active_nodes_q > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : active_nodes_q;
		reported_cnt = '0;
		for (int k = 0; k < MASK_W; k++) begin
			reported_cnt = reported_cnt + CNT_W'(reported_mask_q[k]);
		end
	end

	assign commit_ok_own    = (reported_cnt + CNT_W'(1)) >= required_nodes_q;
	assign commit_ok_remote = own_done_q && commit_ok_own;

	// Request handshake and the entry filter.
	assign req.ready = (state_q == ST_IDLE);
	assign in_fire   = req.valid && req.ready;
	assign entry_ok  = ({1'b0, req.src_node} < node_lim)
		&& ({1'b0, req.tgt_node} < node_lim)
		&& (req.distance_mm > DIST_W'(1));
	assign pend_we   = in_fire && (req.req_type == REQ_ENTRY) && entry_ok
		&& (pend_cnt_q < PCW'(BUFFER_DEPTH));
	assign pend_wdata = '{src: req.src_node, tgt: req.tgt_node, dist_mm: req.distance_mm};

	// Matrix addressing for commits and for both sides of a published pair.
	assign range_we    = (state_q == ST_CMT_WR);
	assign range_waddr = AW'(pend_rd_q.src) * AW'(MAX_NODES) + AW'(pend_rd_q.tgt);
	assign addr_a      = AW'(row_q) * AW'(MAX_NODES) + AW'(col_q);
	assign addr_b      = AW'(col_q) * AW'(MAX_NODES) + AW'(row_q);

	assign row_last = ({1'b0, row_q} == node_lim - CNT_W'(1));
	assign col_last = ({1'b0, col_q} == node_lim - CNT_W'(1));
	assign out_free = !rsp_valid_q || rsp.ready;

	// Pending buffer: written by accepted entries, read during a commit.
	always_ff @(posedge clk) begin
		if (pend_we) begin
			pend_mem[pend_cnt_q[PW-1:0]] <= pend_wdata;
		end
		if (state_q == ST_CMT_RD) begin
			pend_rd_q <= pend_mem[cmt_idx_q[PW-1:0]];
		end
	end

	// Range matrix: one write port for commits, two read ports for publish.
	always_ff @(posedge clk) begin
		if (range_we) begin
			range_mem[range_waddr] <= pend_rd_q.dist_mm;
		end
		if (state_q == ST_PUB_RD) begin
			rd_a_q       <= range_mem[addr_a];
			rd_b_q       <= range_mem[addr_b];
			rd_a_valid_q <= range_valid_q[addr_a];
			rd_b_valid_q <= range_valid_q[addr_b];
		end
	end

	// Valid bits: an entry never written reads as unknown.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_valid_q <= '0;
		end else if (range_we) begin
			range_valid_q[range_waddr] <= 1'b1;
		end
	end

	// Sum and absolute difference of the two directions of a pair.
	always_ff @(posedge clk) begin
		if (state_q == ST_PUB_CALC) begin
			sum_q  <= {1'b0, rd_a_q} + {1'b0, rd_b_q};
			diff_q <= (rd_a_q >= rd_b_q) ? (rd_a_q - rd_b_q) : (rd_b_q - rd_a_q);
		end
	end

	// Consensus selection for the current element.
	always_comb begin
		if (row_q == col_q) begin
			cons_value = '0;
		end else if (rd_a_valid_q && rd_b_valid_q) begin
			cons_value = (diff_q <= diff_threshold_q) ? {1'b0, sum_q[DIST_W:1]} : '1;
		end else if (rd_a_valid_q) begin
			cons_value = {1'b0, rd_a_q};
		end else if (rd_b_valid_q) begin
			cons_value = {1'b0, rd_b_q};
		end else begin
			cons_value = '1;
		end
	end

	// Sequencer, buffer bookkeeping and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			pend_cnt_q      <= '0;
			cmt_idx_q       <= '0;
			reported_mask_q <= '0;
			own_done_q      <= 1'b0;
			overflow_q      <= 1'b0;
			row_q           <= '0;
			col_q           <= '0;
			rsp_valid_q     <= 1'b0;
		end else begin
			// The output register fills with a new element or drains when taken.
			if ((state_q == ST_PUB_OUT) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (req.req_type)
							REQ_ENTRY: begin
								if (pend_we) begin
									pend_cnt_q <= pend_cnt_q + PCW'(1);
								end else if (entry_ok) begin
									overflow_q <= 1'b1;
								end
							end
							REQ_REPORT: begin
								reported_mask_q[req.src_node] <= 1'b1;
							end
							REQ_OWN_END, REQ_REMOTE_END: begin
								// A commit clears the own flag, so it is only set
								// when no commit follows.
								if ((req.req_type == REQ_OWN_END) ? commit_ok_own
									: commit_ok_remote) begin
									if (pend_cnt_q == '0) begin
										reported_mask_q <= '0;
										own_done_q      <= 1'b0;
									end else begin
										cmt_idx_q <= '0;
										state_q   <= ST_CMT_RD;
									end
								end else if (req.req_type == REQ_OWN_END) begin
									own_done_q <= 1'b1;
								end
							end
							REQ_PUBLISH: begin
								if (node_lim != '0) begin
									row_q   <= '0;
									col_q   <= '0;
									state_q <= ST_PUB_RD;
								end
							end
							default: ;
						endcase
					end
				end
				ST_CMT_RD: begin
					state_q <= ST_CMT_WR;
				end
				ST_CMT_WR: begin
					// The entry read last cycle is written to the matrix now.
					if (cmt_idx_q + PCW'(1) == pend_cnt_q) begin
						pend_cnt_q      <= '0;
						reported_mask_q <= '0;
						own_done_q      <= 1'b0;
						state_q         <= ST_IDLE;
					end else begin
						cmt_idx_q <= cmt_idx_q + PCW'(1);
						state_q   <= ST_CMT_RD;
					end
				end
				ST_PUB_RD: begin
					state_q <= ST_PUB_CALC;
				end
				ST_PUB_CALC: begin
					state_q <= ST_PUB_OUT;
				end
				ST_PUB_OUT: begin
					// Hold here until the output register can take the element.
					if (out_free) begin
						rsp_row_q   <= row_q;
						rsp_col_q   <= col_q;
						rsp_range_q <= cons_value;
						rsp_last_q  <= row_last && col_last;
						rsp_ovf_q   <= overflow_q;
						if (col_last) begin
							col_q <= '0;
							if (row_last) begin
								row_q   <= '0;
								state_q <= ST_IDLE;
							end else begin
								row_q   <= row_q + ID_W'(1);
								state_q <= ST_PUB_RD;
							end
						end else begin
							col_q   <= col_q + ID_W'(1);
							state_q <= ST_PUB_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.row_id        = rsp_row_q;
	assign rsp.col_id        = rsp_col_q;
	assign rsp.range_value   = rsp_range_q;
	assign rsp.last_element  = rsp_last_q;
	assign rsp.overflow_seen = rsp_ovf_q;

endmodule
